@@ rtl/positional_pid_speed_control_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef POSITIONAL_PID_SPEED_CONTROL_TOP_DEFINES_SVH
`define POSITIONAL_PID_SPEED_CONTROL_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define PPSC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppsc assertion failed");

// Next-cycle implication, quiet while reset is high.
`define PPSC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppsc assertion failed");

`endif

@@ rtl/ppsc_pkg.sv @@
package ppsc_pkg;

   localparam int GAIN_WIDTH      = 16;
   localparam int TICK_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int TARGET_RESET    = 250;
   localparam int GAIN_P_RESET    = 97;
   localparam int GAIN_I_RESET    = 102;
   localparam int GAIN_D_RESET    = 45;
   localparam int PERIOD_RESET    = 40;
   localparam int INT_LIMIT_RESET = 500;
   localparam int OUT_LIMIT_RESET = 300;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_TARGET_COUNT   = 3'd0,
      REG_GAIN_P         = 3'd1,
      REG_GAIN_I         = 3'd2,
      REG_GAIN_D         = 3'd3,
      REG_PERIOD_TICKS   = 3'd4,
      REG_INTEGRAL_LIMIT = 3'd5,
      REG_OUTPUT_LIMIT   = 3'd6
   } ppsc_reg_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0] p;
      logic [GAIN_WIDTH-1:0] i;
      logic [GAIN_WIDTH-1:0] d;
   } ppsc_gain_type;

endpackage

@@ rtl/ppsc_csr.sv @@
module ppsc_csr #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [ppsc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ppsc_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   output logic signed [COUNT_WIDTH-1:0]            target_count,
   output ppsc_pkg::ppsc_gain_type                  gains,
   output logic [ppsc_pkg::TICK_WIDTH-1:0]          period_ticks,
   output logic [COUNT_WIDTH-2:0]                   integral_limit,
   output logic [COUNT_WIDTH-2:0]                   output_limit
);

   logic signed [COUNT_WIDTH-1:0]           target_ff;
   ppsc_pkg::ppsc_gain_type                 gains_ff;
   logic [ppsc_pkg::TICK_WIDTH-1:0]         period_ff;
   logic [COUNT_WIDTH-2:0]                  int_limit_ff;
   logic [COUNT_WIDTH-2:0]                  out_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= COUNT_WIDTH'(ppsc_pkg::TARGET_RESET);
         gains_ff.p   <= ppsc_pkg::GAIN_WIDTH'(ppsc_pkg::GAIN_P_RESET);
         gains_ff.i   <= ppsc_pkg::GAIN_WIDTH'(ppsc_pkg::GAIN_I_RESET);
         gains_ff.d   <= ppsc_pkg::GAIN_WIDTH'(ppsc_pkg::GAIN_D_RESET);
         period_ff    <= ppsc_pkg::TICK_WIDTH'(ppsc_pkg::PERIOD_RESET);
         int_limit_ff <= (COUNT_WIDTH-1)'(ppsc_pkg::INT_LIMIT_RESET);
         out_limit_ff <= (COUNT_WIDTH-1)'(ppsc_pkg::OUT_LIMIT_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            ppsc_pkg::REG_TARGET_COUNT:   target_ff    <= csr_wdata[COUNT_WIDTH-1:0];
            ppsc_pkg::REG_GAIN_P:         gains_ff.p   <= csr_wdata[ppsc_pkg::GAIN_WIDTH-1:0];
            ppsc_pkg::REG_GAIN_I:         gains_ff.i   <= csr_wdata[ppsc_pkg::GAIN_WIDTH-1:0];
            ppsc_pkg::REG_GAIN_D:         gains_ff.d   <= csr_wdata[ppsc_pkg::GAIN_WIDTH-1:0];
            ppsc_pkg::REG_PERIOD_TICKS:   period_ff    <= csr_wdata[ppsc_pkg::TICK_WIDTH-1:0];
            ppsc_pkg::REG_INTEGRAL_LIMIT: int_limit_ff <= csr_wdata[COUNT_WIDTH-2:0];
            ppsc_pkg::REG_OUTPUT_LIMIT:   out_limit_ff <= csr_wdata[COUNT_WIDTH-2:0];
            default: ;
         endcase
      end
   end

   assign target_count   = target_ff;
   assign gains          = gains_ff;
   assign period_ticks   = period_ff;
   assign integral_limit = int_limit_ff;
   assign output_limit   = out_limit_ff;

endmodule

@@ rtl/ppsc_step.sv @@
module ppsc_step #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [COUNT_WIDTH-1:0]        in_count,
   input  logic signed [COUNT_WIDTH-1:0]        target_count,
   input  logic [ppsc_pkg::TICK_WIDTH-1:0]      period_ticks,
   input  logic [COUNT_WIDTH-2:0]               integral_limit,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [COUNT_WIDTH:0]          out_err,
   output logic signed [COUNT_WIDTH-1:0]        out_integral,
   output logic signed [COUNT_WIDTH+1:0]        out_diff
);

   localparam int EW = COUNT_WIDTH + 1;
   localparam int SW = COUNT_WIDTH + 2;

   logic                                 s0_valid_ff;
   logic signed [COUNT_WIDTH-1:0]        s0_count_ff;
   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   logic signed [EW-1:0]                 s1_err_ff;
   logic signed [COUNT_WIDTH-1:0]        s1_integral_ff;
   logic signed [SW-1:0]                 s1_diff_ff;

   logic [ppsc_pkg::TICK_WIDTH-1:0]      tick_ff;
   logic [ppsc_pkg::TICK_WIDTH-1:0]      tick_in;
   logic signed [EW-1:0]                 prev_err_ff;
   logic signed [COUNT_WIDTH-1:0]        integral_ff;
   logic signed [COUNT_WIDTH-1:0]        integral_in;

   logic                                 s1_en;
   logic                                 advance;
   logic [ppsc_pkg::TICK_WIDTH-1:0]      tick_next;
   logic                                 control;
   logic signed [EW-1:0]                 err;
   logic signed [SW-1:0]                 int_sum;
   logic signed [SW-1:0]                 int_lim;
   logic signed [SW-1:0]                 diff;

   assign s1_en    = !s1_valid_ff || out_ready;
   assign in_ready = !s0_valid_ff || s1_en;
   assign advance  = s0_valid_ff && s1_en;

   assign tick_next = tick_ff + 1'b1;
   assign control   = tick_next >= period_ticks;

   assign err     = EW'(target_count) - EW'(s0_count_ff);
   assign int_sum = SW'(integral_ff) + SW'(err);
   assign int_lim = $signed(SW'(integral_limit));
   assign diff    = SW'(err) - SW'(prev_err_ff);

   always_comb begin
      priority if (int_sum > int_lim) begin
         integral_in = int_lim[COUNT_WIDTH-1:0];
      end else if (int_sum < -int_lim) begin
         integral_in = COUNT_WIDTH'(-int_lim);
      end else begin
         integral_in = int_sum[COUNT_WIDTH-1:0];
      end
   end

   assign tick_in     = control ? '0 : tick_next;
   assign s1_valid_in = s0_valid_ff && control;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         tick_ff     <= '0;
         prev_err_ff <= '0;
         integral_ff <= '0;
      end else begin
         if (in_ready) begin
            s0_valid_ff <= in_valid;
         end
         if (s1_en) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (advance) begin
            tick_ff <= tick_in;
            if (control) begin
               prev_err_ff <= err;
               integral_ff <= integral_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s0_count_ff <= in_count;
      end
      if (advance && control) begin
         s1_err_ff      <= err;
         s1_integral_ff <= integral_in;
         s1_diff_ff     <= diff;
      end
   end

   assign out_valid    = s1_valid_ff;
   assign out_err      = s1_err_ff;
   assign out_integral = s1_integral_ff;
   assign out_diff     = s1_diff_ff;

endmodule

@@ rtl/ppsc_mul.sv @@
module ppsc_mul #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_ready,
   input  logic signed [COUNT_WIDTH:0]                  in_err,
   input  logic signed [COUNT_WIDTH-1:0]                in_integral,
   input  logic signed [COUNT_WIDTH+1:0]                in_diff,
   input  ppsc_pkg::ppsc_gain_type                      gains,
   output logic                                         out_valid,
   input  logic                                         out_ready,
   output logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH+1:0] out_p,
   output logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH:0]   out_i,
   output logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH+2:0] out_d
);

   localparam int GW = ppsc_pkg::GAIN_WIDTH + 1;

   logic                                        valid_ff;
   logic                                        en;
   logic signed [GW-1:0]                        gp;
   logic signed [GW-1:0]                        gi;
   logic signed [GW-1:0]                        gd;
   logic signed [GW+COUNT_WIDTH:0]              p_ff;
   logic signed [GW+COUNT_WIDTH-1:0]            i_ff;
   logic signed [GW+COUNT_WIDTH+1:0]            d_ff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   assign gp = $signed({1'b0, gains.p});
   assign gi = $signed({1'b0, gains.i});
   assign gd = $signed({1'b0, gains.d});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         p_ff <= gp * in_err;
         i_ff <= gi * in_integral;
         d_ff <= gd * in_diff;
      end
   end

   assign out_valid = valid_ff;
   assign out_p     = p_ff;
   assign out_i     = i_ff;
   assign out_d     = d_ff;

endmodule

@@ rtl/ppsc_out.sv @@
module ppsc_out #(
   parameter int COUNT_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH+1:0] in_p,
   input  logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH:0]   in_i,
   input  logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH+2:0] in_d,
   input  logic [COUNT_WIDTH-2:0]                             output_limit,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output logic signed [COUNT_WIDTH-1:0]                      out_drive
);

   localparam int SUMW = ppsc_pkg::GAIN_WIDTH + COUNT_WIDTH + 5;

   logic                          valid_ff;
   logic signed [COUNT_WIDTH-1:0] drive_ff;
   logic signed [COUNT_WIDTH-1:0] drive_in;
   logic                          en;
   logic signed [SUMW-1:0]        sum;
   logic signed [SUMW-1:0]        scaled;
   logic signed [SUMW-1:0]        lim;
   logic signed [COUNT_WIDTH-1:0] clamped;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   assign sum    = SUMW'(in_p) + SUMW'(in_i) + SUMW'(in_d);
   assign scaled = sum >>> GAIN_FRAC_BITS;
   assign lim    = $signed(SUMW'(output_limit));

   always_comb begin
      priority if (scaled > lim) begin
         clamped = lim[COUNT_WIDTH-1:0];
      end else if (scaled < -lim) begin
         clamped = COUNT_WIDTH'(-lim);
      end else begin
         clamped = scaled[COUNT_WIDTH-1:0];
      end
   end

   assign drive_in = -clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         drive_ff <= drive_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_drive = drive_ff;

endmodule

@@ rtl/positional_pid_speed_control_top.sv @@
// Positional PID speed controller. Each req transaction is one timer tick carrying
// the encoder pulse count; every period_ticks-th tick (every tick when period_ticks
// is zero) is a control step and yields exactly one rsp transaction with the negated,
// clamped drive, other ticks yield none. The block takes one tick per clock cycle
// unless a stall on rsp backs up to req; a control step reaches rsp_tdata through
// an input register, the error and integral stage, the three gain multipliers and
// the sum, shift and clamp stage. Stalls on rsp back up stage by stage, so empty
// stages still take ticks while a result waits. Write the csr registers only while
// no tick is in flight.
module positional_pid_speed_control_top #(
   parameter int COUNT_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // [COUNT_WIDTH-1:0] encoder_count, zero filled above
   input  logic [((COUNT_WIDTH+7)/8)*8-1:0]         req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [COUNT_WIDTH-1:0] motor_drive, zero filled above
   output logic [((COUNT_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [ppsc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ppsc_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   localparam int RSP_W = ((COUNT_WIDTH + 7) / 8) * 8;

   logic signed [COUNT_WIDTH-1:0]                        target_count;
   ppsc_pkg::ppsc_gain_type                              gains;
   logic [ppsc_pkg::TICK_WIDTH-1:0]                      period_ticks;
   logic [COUNT_WIDTH-2:0]                               integral_limit;
   logic [COUNT_WIDTH-2:0]                               output_limit;

   logic                                                 step_valid;
   logic                                                 step_ready;
   logic signed [COUNT_WIDTH:0]                          step_err;
   logic signed [COUNT_WIDTH-1:0]                        step_integral;
   logic signed [COUNT_WIDTH+1:0]                        step_diff;

   logic                                                 mul_valid;
   logic                                                 mul_ready;
   logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH+1:0]   mul_p;
   logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH:0]     mul_i;
   logic signed [ppsc_pkg::GAIN_WIDTH+COUNT_WIDTH+2:0]   mul_d;

   logic signed [COUNT_WIDTH-1:0]                        motor_drive;

   ppsc_csr #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .target_count   (target_count),
      .gains          (gains),
      .period_ticks   (period_ticks),
      .integral_limit (integral_limit),
      .output_limit   (output_limit)
   );

   ppsc_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_count       (req_tdata[COUNT_WIDTH-1:0]),
      .target_count   (target_count),
      .period_ticks   (period_ticks),
      .integral_limit (integral_limit),
      .out_valid      (step_valid),
      .out_ready      (step_ready),
      .out_err        (step_err),
      .out_integral   (step_integral),
      .out_diff       (step_diff)
   );

   ppsc_mul #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_mul (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (step_valid),
      .in_ready    (step_ready),
      .in_err      (step_err),
      .in_integral (step_integral),
      .in_diff     (step_diff),
      .gains       (gains),
      .out_valid   (mul_valid),
      .out_ready   (mul_ready),
      .out_p       (mul_p),
      .out_i       (mul_i),
      .out_d       (mul_d)
   );

   ppsc_out #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mul_valid),
      .in_ready     (mul_ready),
      .in_p         (mul_p),
      .in_i         (mul_i),
      .in_d         (mul_d),
      .output_limit (output_limit),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_drive    (motor_drive)
   );

   assign rsp_tdata = RSP_W'($unsigned(motor_drive));

endmodule

@@ rtl/ppsc_checker.sv @@
`include "positional_pid_speed_control_top_defines.svh"

module ppsc_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((COUNT_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input logic                                 csr_valid,
   input logic                                 csr_ready
);

   localparam logic [COUNT_WIDTH-1:0] MOST_NEG = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   logic rsp_wait;

   assign rsp_wait = rsp_tvalid && !rsp_tready;

   `PPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata))
   `PPSC_ASSERT_NOW(a_drive_range, clock, reset, rsp_tvalid, rsp_tdata[COUNT_WIDTH-1:0] != MOST_NEG)
   `PPSC_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)
   `PPSC_ASSERT_NOW(a_no_deadlock, clock, reset, !rsp_wait, req_tready)
   `PPSC_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind positional_pid_speed_control_top ppsc_checker #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_ppsc_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int IDX_W = ppsc_pkg::CSR_INDEX_WIDTH;
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int FRAC_BITS     = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int ITEM_TARGET   = 1800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [IDX_W-1:0]                    csr_index = '0;
   logic [ppsc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   positional_pid_speed_control_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // controller settings as the block should hold them
   logic signed [15:0] cfg_target     = 16'(ppsc_pkg::TARGET_RESET);
   logic [15:0]        cfg_gain_p     = 16'(ppsc_pkg::GAIN_P_RESET);
   logic [15:0]        cfg_gain_i     = 16'(ppsc_pkg::GAIN_I_RESET);
   logic [15:0]        cfg_gain_d     = 16'(ppsc_pkg::GAIN_D_RESET);
   logic [15:0]        cfg_period     = 16'(ppsc_pkg::PERIOD_RESET);
   logic [14:0]        cfg_int_limit  = 15'(ppsc_pkg::INT_LIMIT_RESET);
   logic [14:0]        cfg_out_limit  = 15'(ppsc_pkg::OUT_LIMIT_RESET);

   // controller state
   logic [15:0]        tick_count     = '0;
   logic signed [16:0] last_error     = '0;
   logic signed [15:0] integral_acc   = '0;

   logic [15:0] tick_backlog[$];
   logic [15:0] drive_expected[$];
   int unsigned ticks_queued = 0;
   int unsigned ticks_taken  = 0;
   int unsigned drive_errors = 0;
   bit          no_gaps  = 1'b0;
   bit          hold_arm = 1'b0;
   bit          hold_done;
   int unsigned send_gap;
   int unsigned recv_gap;
   int unsigned hold_left;

   function automatic longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   function automatic void predict_drive(logic [15:0] count);
      longint err;
      longint acc;
      longint sum;
      longint drive;
      tick_count = tick_count + 16'd1;
      if (cfg_period != 16'd0 && tick_count < cfg_period) return;
      tick_count = '0;
      err = longint'(cfg_target) - longint'($signed(count));
      acc = clamp_sym(longint'(integral_acc) + err, longint'(cfg_int_limit));
      sum = longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * acc
          + longint'(cfg_gain_d) * (err - longint'(last_error));
      last_error   = err[16:0];
      integral_acc = acc[15:0];
      drive = clamp_sym(sum >>> FRAC_BITS, longint'(cfg_out_limit));
      drive_expected.push_back(16'(-drive));
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_count();
      int unsigned roll = $urandom_range(0, 99);
      if (roll < 55) return 16'(int'(cfg_target) + int'($urandom_range(0, 64)) - 32);
      if (roll < 75) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_setting(logic [IDX_W-1:0] which);
      logic [31:0] word = $urandom;
      int unsigned pick = $urandom_range(0, 9);
      case (which)
         ppsc_pkg::REG_TARGET_COUNT: begin
            if (pick == 0) word[15:0] = 16'h8000;
            else if (pick == 1) word[15:0] = 16'h7fff;
            else if (pick < 7) word[15:0] = 16'($urandom_range(0, 600) - 300);
         end
         ppsc_pkg::REG_GAIN_P, ppsc_pkg::REG_GAIN_I, ppsc_pkg::REG_GAIN_D: begin
            if (pick == 0) word[15:0] = 16'h0000;
            else if (pick == 1) word[15:0] = 16'hffff;
            else if (pick < 8) word[15:0] = 16'($urandom_range(0, 400));
         end
         ppsc_pkg::REG_PERIOD_TICKS: begin
            if (pick < 8) word[15:0] = 16'($urandom_range(0, 5));
            else word[15:0] = 16'($urandom_range(6, 48));
         end
         ppsc_pkg::REG_INTEGRAL_LIMIT, ppsc_pkg::REG_OUTPUT_LIMIT: begin
            if (pick == 0) word[14:0] = 15'h0000;
            else if (pick == 1) word[14:0] = 15'h7fff;
            else if (pick < 8) word[14:0] = 15'($urandom_range(0, 2000));
         end
         default: ;
      endcase
      return word;
   endfunction

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ppsc_pkg::REG_TARGET_COUNT:   cfg_target    = val[15:0];
         ppsc_pkg::REG_GAIN_P:         cfg_gain_p    = val[15:0];
         ppsc_pkg::REG_GAIN_I:         cfg_gain_i    = val[15:0];
         ppsc_pkg::REG_GAIN_D:         cfg_gain_d    = val[15:0];
         ppsc_pkg::REG_PERIOD_TICKS:   cfg_period    = val[15:0];
         ppsc_pkg::REG_INTEGRAL_LIMIT: cfg_int_limit = val[14:0];
         ppsc_pkg::REG_OUTPUT_LIMIT:   cfg_out_limit = val[14:0];
         default: ;
      endcase
   endtask

   task automatic push_count(logic [15:0] count);
      tick_backlog.push_back(count);
      ticks_queued++;
   endtask

   task automatic run_ticks(int unsigned n);
      @(negedge clock);
      repeat (n) push_count(pick_count());
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (ticks_taken != ticks_queued || drive_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_mismatch(bit orphan, logic [15:0] want, logic [15:0] got);
      drive_errors++;
      if (drive_errors <= 10) begin
         if (orphan) $display("motor_drive %0d with no result pending", $signed(got));
         else $display("motor_drive mismatch: expected %0d, got %0d",
                       $signed(want), $signed(got));
      end
   endtask

   // tick sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (tick_backlog.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= tick_backlog.pop_front();
            send_gap   <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // drive receiver, with one long hold-off when armed
   always @(posedge clock) begin
      int unsigned g;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else if (recv_gap != 0) begin
         rsp_tready <= 1'b0;
         recv_gap   <= recv_gap - 1;
      end else if (rsp_tvalid && rsp_tready) begin
         g = pick_gap();
         rsp_tready <= (g == 0);
         recv_gap   <= (g == 0) ? 0 : g - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // check drives, then predict from accepted ticks
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (drive_expected.size() == 0) begin
               note_mismatch(1'b1, '0, rsp_tdata);
            end else begin
               want = drive_expected.pop_front();
               if (rsp_tdata !== want) note_mismatch(1'b0, want, rsp_tdata);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_drive(req_tdata);
            ticks_taken++;
         end
      end
   end

   initial begin
      int unsigned phase_no;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: two control periods
      run_ticks(80);
      wait_idle();

      // every tick a control step, saturated gains and limits
      write_reg(ppsc_pkg::REG_PERIOD_TICKS, 32'h0000_0000);
      write_reg(ppsc_pkg::REG_GAIN_P, 32'h0000_ffff);
      write_reg(ppsc_pkg::REG_GAIN_I, 32'hffff_ffff);
      write_reg(ppsc_pkg::REG_GAIN_D, 32'h0000_ffff);
      write_reg(ppsc_pkg::REG_INTEGRAL_LIMIT, 32'h0000_7fff);
      write_reg(ppsc_pkg::REG_OUTPUT_LIMIT, 32'h0000_7fff);
      write_reg(ppsc_pkg::REG_TARGET_COUNT, 32'hffff_8000);
      @(negedge clock);
      push_count(16'h7fff);
      push_count(16'h8000);
      push_count(16'h0000);
      push_count(16'hffff);
      wait_idle();

      write_reg(ppsc_pkg::REG_TARGET_COUNT, 32'h0000_7fff);
      @(negedge clock);
      push_count(16'h8000);
      push_count(16'h7fff);
      push_count(16'h0001);
      push_count(16'h8000);
      wait_idle();

      // zero limits
      write_reg(ppsc_pkg::REG_INTEGRAL_LIMIT, 32'hffff_8000);
      write_reg(ppsc_pkg::REG_OUTPUT_LIMIT, 32'h0000_0000);
      @(negedge clock);
      push_count(16'h8000);
      push_count(16'h7fff);
      wait_idle();

      // ignored index, zero gains, masked upper bits
      write_reg(REG_UNUSED, 32'hffff_ffff);
      write_reg(ppsc_pkg::REG_GAIN_P, 32'hffff_0000);
      write_reg(ppsc_pkg::REG_GAIN_I, 32'h0000_0000);
      write_reg(ppsc_pkg::REG_GAIN_D, 32'h0000_0000);
      write_reg(ppsc_pkg::REG_INTEGRAL_LIMIT, 32'hdead_c123);
      write_reg(ppsc_pkg::REG_OUTPUT_LIMIT, 32'hbeef_8100);
      @(negedge clock);
      push_count(16'h1234);
      push_count(16'hedcb);
      wait_idle();

      // lower the period below the running count
      write_reg(ppsc_pkg::REG_GAIN_P, 32'h0000_0061);
      write_reg(ppsc_pkg::REG_GAIN_I, 32'h0000_0066);
      write_reg(ppsc_pkg::REG_GAIN_D, 32'h0000_002d);
      write_reg(ppsc_pkg::REG_PERIOD_TICKS, 32'h0000_ffff);
      @(negedge clock);
      repeat (6) push_count(pick_count());
      wait_idle();
      write_reg(ppsc_pkg::REG_PERIOD_TICKS, 32'h0000_0003);
      run_ticks(4);
      wait_idle();

      phase_no = 0;
      while (ticks_queued < ITEM_TARGET) begin
         for (int r = ppsc_pkg::REG_TARGET_COUNT; r <= ppsc_pkg::REG_OUTPUT_LIMIT; r++) begin
            if ($urandom_range(0, 1) != 0)
               write_reg(IDX_W'(r), pick_setting(IDX_W'(r)));
         end
         if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
         if (phase_no == 5) begin
            write_reg(ppsc_pkg::REG_PERIOD_TICKS, 32'h0000_0000);
            @(negedge clock);
            no_gaps  = 1'b1;
            hold_arm = 1'b1;
            run_ticks(150);
         end else begin
            @(negedge clock);
            no_gaps = ($urandom_range(0, 3) == 0);
            run_ticks($urandom_range(20, 100));
         end
         wait_idle();
         phase_no++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (drive_errors == 0 && drive_expected.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ positional_pid_speed_control_top.f @@
+incdir+rtl
rtl/ppsc_pkg.sv
rtl/ppsc_csr.sv
rtl/ppsc_step.sv
rtl/ppsc_mul.sv
rtl/ppsc_out.sv
rtl/positional_pid_speed_control_top.sv
rtl/ppsc_checker.sv
sim/tb.sv
